FILE: rtl/core/ugi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugi_pkg: shared types, constants and rounding helper
// Single-precision coefficient patterns, special codes and the
// round-to-nearest-even packer used by every arithmetic unit.
// ----------------------------------------------------------------------------
package ugi_pkg;

  typedef logic [31:0] fp32_t;

  // Rational approximation coefficients, rounded to single precision
  localparam fp32_t COEF_A1 = 32'hC21EC98E;
  localparam fp32_t COEF_A2 = 32'h435CF234;
  localparam fp32_t COEF_A3 = 32'hC389F6D9;
  localparam fp32_t COEF_A4 = 32'h430A5B96;
  localparam fp32_t COEF_A5 = 32'hC1F55182;
  localparam fp32_t COEF_A6 = 32'h40206C99;
  localparam fp32_t COEF_B1 = 32'hC259E786;
  localparam fp32_t COEF_B2 = 32'h432195F9;
  localparam fp32_t COEF_B3 = 32'hC31BB2F0;
  localparam fp32_t COEF_B4 = 32'h42859A46;
  localparam fp32_t COEF_B5 = 32'hC1547DAC;
  localparam fp32_t FP_ONE      = 32'h3F800000;
  localparam fp32_t FP_NEG_HALF = 32'hBF000000;

  localparam fp32_t QNAN_BITS = 32'h7FC00000;
  localparam fp32_t INF_BITS  = 32'h7F800000;

  localparam int HORNER_STEPS = 5;

  // Addends of the Horner steps, in order
  localparam fp32_t NUM_ADD [HORNER_STEPS] = '{COEF_A2, COEF_A3, COEF_A4, COEF_A5, COEF_A6};
  localparam fp32_t DEN_ADD [HORNER_STEPS] = '{COEF_B2, COEF_B3, COEF_B4, COEF_B5, FP_ONE};

  // Reciprocal: quotient bits developed and bits per pipeline stage
  localparam int RECIP_QBITS = 25;
  localparam int RECIP_STEP  = 5;

  // Round to nearest even and pack; keep holds the hidden bit at [23]
  function automatic fp32_t round_pack(input logic       sgn,
                                       input logic [9:0] ex,
                                       input logic [23:0] keep,
                                       input logic       rnd,
                                       input logic       stk);
    logic [24:0] inc;
    logic [9:0]  ex_f;
    inc  = {1'b0, keep} + {24'd0, (rnd & (stk | keep[0]))};
    ex_f = ex + {9'd0, inc[24]};
    return {sgn, ex_f[7:0], (inc[24] ? inc[23:1] : inc[22:0])};
  endfunction

endpackage

FILE: rtl/core/ugi_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugi_in_if: uniform word channel
// Valid/ready channel carrying one uniform word per transaction.
// ----------------------------------------------------------------------------
interface ugi_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] uniform_word;

  modport source (output valid, output uniform_word, input ready);
  modport sink   (input valid, input uniform_word, output ready);
endinterface

FILE: rtl/core/ugi_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugi_out_if: Gaussian sample channel
// Valid/ready channel carrying one single-precision pattern per transaction.
// ----------------------------------------------------------------------------
interface ugi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] gaussian_bits;

  modport source (output valid, output gaussian_bits, input ready);
  modport sink   (input valid, input gaussian_bits, output ready);
endinterface

FILE: rtl/core/ugi_i2f.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugi_i2f: unsigned word to scaled single precision
// Two stages: leading-zero search and shift, then rounding. The result is
// the word rounded to single precision and scaled by 2^-31.
// ----------------------------------------------------------------------------
module ugi_i2f (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [31:0]    in_word,
  output logic           out_vld,
  output ugi_pkg::fp32_t out_fp
);

  logic [4:0]  lz;
  logic [31:0] norm_r;
  logic [4:0]  lz_r;
  logic        zero_r;
  logic        vld1_r;
  logic        vld2_r;
  logic [9:0]  ex;
  ugi_pkg::fp32_t res;
  ugi_pkg::fp32_t out_r;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (in_word[i]) lz = 5'(31 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_r <= in_word << lz;
      lz_r   <= lz;
      zero_r <= (in_word == 32'd0);
    end
  end

  // Scaled exponent: 127 + 31 - lz - 31
  always_comb begin
    ex  = 10'd127 - {5'd0, lz_r};
    res = zero_r ? 32'd0
                 : ugi_pkg::round_pack(1'b0, ex, norm_r[31:8], norm_r[7], |norm_r[6:0]);
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= res;
  end

  assign out_vld = vld2_r;
  assign out_fp  = out_r;

endmodule

FILE: rtl/core/ugi_fadd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugi_fadd: single-precision adder
// Two stages: order and align, then add, normalize and round to nearest
// even. Operands are normal numbers or zeros.
// ----------------------------------------------------------------------------
module ugi_fadd (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  ugi_pkg::fp32_t a,
  input  ugi_pkg::fp32_t b,
  output logic           out_vld,
  output ugi_pkg::fp32_t out_fp
);

  ugi_pkg::fp32_t big;
  ugi_pkg::fp32_t sml;
  logic [26:0] m_big;
  logic [26:0] m_sml;
  logic [26:0] shifted;
  logic [26:0] al;
  logic [7:0]  d;
  logic        lost;

  logic        sgn_r;
  logic [7:0]  exp_r;
  logic [26:0] mb_r;
  logic [26:0] ms_r;
  logic        sub_r;
  logic        bz_r;
  logic        zs_r;
  logic        vld1_r;
  logic        vld2_r;

  logic [27:0] sum;
  logic [26:0] n0;
  logic [26:0] n;
  logic [4:0]  lz;
  logic [9:0]  ex;
  ugi_pkg::fp32_t res;
  ugi_pkg::fp32_t out_r;

  // Order by magnitude and align the smaller operand
  always_comb begin
    big     = (a[30:0] >= b[30:0]) ? a : b;
    sml     = (a[30:0] >= b[30:0]) ? b : a;
    m_big   = {(big[30:23] != 8'd0), big[22:0], 3'b000};
    m_sml   = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
    d       = big[30:23] - sml[30:23];
    shifted = m_sml >> d[4:0];
    lost    = |(m_sml & ~(27'h7FFFFFF << d[4:0]));
    if (d >= 8'd27) begin
      al = {26'd0, |m_sml};
    end else begin
      al = {shifted[26:1], shifted[0] | lost};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sgn_r <= big[31];
      exp_r <= big[30:23];
      mb_r  <= m_big;
      ms_r  <= al;
      sub_r <= a[31] ^ b[31];
      bz_r  <= (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      zs_r  <= a[31] & b[31];
    end
  end

  // Add, renormalize, round
  always_comb begin
    sum = sub_r ? ({1'b0, mb_r} - {1'b0, ms_r}) : ({1'b0, mb_r} + {1'b0, ms_r});
    n0  = sum[26:0];
    lz  = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (n0[i]) lz = 5'(26 - i);
    end
    if (sum[27]) begin
      n  = {sum[27:2], sum[1] | sum[0]};
      ex = {2'b00, exp_r} + 10'd1;
    end else begin
      n  = n0 << lz;
      ex = {2'b00, exp_r} - {5'd0, lz};
    end
    if (sum == 28'd0) begin
      res = {bz_r & zs_r, 31'd0};
    end else begin
      res = ugi_pkg::round_pack(sgn_r, ex, n[26:3], n[2], |n[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= res;
  end

  assign out_vld = vld2_r;
  assign out_fp  = out_r;

endmodule

FILE: rtl/core/ugi_fmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugi_fmul: single-precision multiplier
// Two stages: 24x24 significand product, then normalize and round to
// nearest even. Operands are normal numbers or zeros.
// ----------------------------------------------------------------------------
module ugi_fmul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  ugi_pkg::fp32_t a,
  input  ugi_pkg::fp32_t b,
  output logic           out_vld,
  output ugi_pkg::fp32_t out_fp
);

  logic [23:0] ma;
  logic [23:0] mb;
  logic [47:0] prod_r;
  logic        sgn_r;
  logic [9:0]  exp_r;
  logic        zero_r;
  logic        vld1_r;
  logic        vld2_r;
  ugi_pkg::fp32_t res;
  ugi_pkg::fp32_t out_r;

  assign ma = {(a[30:23] != 8'd0), a[22:0]};
  assign mb = {(b[30:23] != 8'd0), b[22:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= ma * mb;
      sgn_r  <= a[31] ^ b[31];
      exp_r  <= {2'b00, a[30:23]} + {2'b00, b[30:23]} - 10'd127;
      zero_r <= (a[30:23] == 8'd0) || (b[30:23] == 8'd0);
    end
  end

  always_comb begin
    if (zero_r) begin
      res = {sgn_r, 31'd0};
    end else if (prod_r[47]) begin
      res = ugi_pkg::round_pack(sgn_r, exp_r + 10'd1, prod_r[47:24], prod_r[23],
                                |prod_r[22:0]);
    end else begin
      res = ugi_pkg::round_pack(sgn_r, exp_r, prod_r[46:23], prod_r[22], |prod_r[21:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= res;
  end

  assign out_vld = vld2_r;
  assign out_fp  = out_r;

endmodule

FILE: rtl/core/ugi_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugi_recip: pipelined single-precision reciprocal
// Restoring division of 2 by the significand, a fixed number of quotient
// bits per stage, then one rounding stage. A zero divisor is flagged.
// ----------------------------------------------------------------------------
module ugi_recip (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  ugi_pkg::fp32_t den,
  output logic           out_vld,
  output logic           out_dz,
  output ugi_pkg::fp32_t out_fp
);

  localparam int NSTG = ugi_pkg::RECIP_QBITS / ugi_pkg::RECIP_STEP;
  localparam int QW   = ugi_pkg::RECIP_QBITS;

  typedef struct packed {
    logic        sgn;
    logic [7:0]  ex;
    logic        one;
    logic        dz;
    logic [23:0] m;
  } rcp_side_t;

  logic [QW-1:0] rem_r [NSTG];
  logic [QW-1:0] q_r   [NSTG];
  rcp_side_t     side_r[NSTG];
  logic          vld_r [NSTG];

  rcp_side_t     in_side;
  logic [9:0]    ex_q;
  ugi_pkg::fp32_t res;
  ugi_pkg::fp32_t out_r;
  logic          out_vld_r;
  logic          out_dz_r;

  assign in_side = '{sgn: den[31], ex: den[30:23], one: (den[22:0] == 23'd0),
                     dz: (den[30:23] == 8'd0), m: {1'b1, den[22:0]}};

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic [QW-1:0] rem_i;
    logic [QW-1:0] q_i;
    rcp_side_t     side_i;
    logic          vld_i;
    logic [QW-1:0] rem_o;
    logic [QW-1:0] q_o;

    if (g == 0) begin : g_first
      // Dividend 2 at the divisor's scale
      assign rem_i  = QW'(1) << (QW - 1);
      assign q_i    = '0;
      assign side_i = in_side;
      assign vld_i  = in_vld;
    end else begin : g_next
      assign rem_i  = rem_r[g-1];
      assign q_i    = q_r[g-1];
      assign side_i = side_r[g-1];
      assign vld_i  = vld_r[g-1];
    end

    always_comb begin
      rem_o = rem_i;
      q_o   = q_i;
      for (int j = 0; j < ugi_pkg::RECIP_STEP; j++) begin
        if (rem_o >= {1'b0, side_i.m}) begin
          rem_o = rem_o - {1'b0, side_i.m};
          q_o   = {q_o[QW-2:0], 1'b1};
        end else begin
          q_o   = {q_o[QW-2:0], 1'b0};
        end
        rem_o = rem_o << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_o;
        q_r[g]    <= q_o;
        side_r[g] <= side_i;
      end
    end
  end

  // Round the quotient; an exact power of two bypasses the division
  always_comb begin
    ex_q = 10'd253 - {2'b00, side_r[NSTG-1].ex};
    if (side_r[NSTG-1].dz) begin
      res = {side_r[NSTG-1].sgn, 31'd0};
    end else if (side_r[NSTG-1].one) begin
      res = {side_r[NSTG-1].sgn, 8'd254 - side_r[NSTG-1].ex, 23'd0};
    end else begin
      res = ugi_pkg::round_pack(side_r[NSTG-1].sgn, ex_q, q_r[NSTG-1][QW-1:1],
                                q_r[NSTG-1][0], (rem_r[NSTG-1] != '0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r    <= res;
      out_dz_r <= side_r[NSTG-1].dz;
    end
  end

  assign out_vld = out_vld_r;
  assign out_dz  = out_dz_r;
  assign out_fp  = out_r;

endmodule

FILE: rtl/core/uniform_to_gaussian_icdf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_to_gaussian_icdf_core: uniform word to Gaussian sample
// Central-region rational inverse normal CDF in single precision, built as
// one stall-able pipeline of adders, multipliers and a reciprocal unit.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload                        | handshake
//  ---------+-----------+--------------------------------+-------------
//  in_ch    | sink      | uniform_word  [31:0] unsigned  | valid/ready
//  out_ch   | source    | gaussian_bits [31:0] fp32 bits | valid/ready
//
//  One transaction enters per cycle while the pipeline advances; the path
//  from input to output register runs through the conversion, the Horner
//  chain, the six-stage reciprocal and the final multiply.
//  rst_n is synchronous, active low, and clears every valid bit.
//  Every stage advances together whenever the output register is empty or
//  being taken; a stall freezes the whole pipeline, dropping nothing.
//
module uniform_to_gaussian_icdf_core (
  input  logic     clk,
  input  logic     rst_n,
  ugi_in_if.sink   in_ch,
  ugi_out_if.source out_ch
);

  localparam int HS = ugi_pkg::HORNER_STEPS;
  localparam int R_DEPTH   = 4 * (HS - 1);  // r taps for later Horner steps
  localparam int Z_DEPTH   = 4 * HS + 2;    // z waits for the numerator
  localparam int NZ_DEPTH  = 4;             // numerator waits for reciprocal

  logic adv;

  logic           u_vld, z_vld, r_vld;
  ugi_pkg::fp32_t u_fp, z_fp, r_fp;

  ugi_pkg::fp32_t r_dly_r [R_DEPTH];
  ugi_pkg::fp32_t z_dly_r [Z_DEPTH];

  logic           nm_vld [HS];
  logic           na_vld [HS];
  logic           dm_vld [HS];
  logic           da_vld [HS];
  ugi_pkg::fp32_t nm_fp  [HS];
  ugi_pkg::fp32_t na_fp  [HS];
  ugi_pkg::fp32_t dm_fp  [HS];
  ugi_pkg::fp32_t da_fp  [HS];

  logic           nz_vld;
  ugi_pkg::fp32_t nz_fp;
  logic           nz_dly_vld_r [NZ_DEPTH];
  ugi_pkg::fp32_t nz_dly_r     [NZ_DEPTH];

  logic           t_vld;
  logic           t_dz;
  ugi_pkg::fp32_t t_fp;

  logic           p_vld;
  ugi_pkg::fp32_t p_fp;

  logic           spec;
  ugi_pkg::fp32_t spec_val;
  logic           spec_d1_r, spec_d2_r;
  ugi_pkg::fp32_t spec_val_d1_r, spec_val_d2_r;

  logic           out_vld_r;
  ugi_pkg::fp32_t out_bits_r;

  // Advance everything when the output register can take a new value
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // u = word * 2^-31
  ugi_i2f u_i2f (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(in_ch.valid), .in_word(in_ch.uniform_word),
    .out_vld(u_vld), .out_fp(u_fp)
  );

  // z = u - 0.5
  ugi_fadd u_sub (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(u_vld),
    .a(u_fp), .b(ugi_pkg::FP_NEG_HALF),
    .out_vld(z_vld), .out_fp(z_fp)
  );

  // r = z * z
  ugi_fmul u_sq (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(z_vld),
    .a(z_fp), .b(z_fp),
    .out_vld(r_vld), .out_fp(r_fp)
  );

  // Hold copies of r and z in step with the Horner chain
  always_ff @(posedge clk) begin
    if (adv) begin
      r_dly_r[0] <= r_fp;
      for (int i = 1; i < R_DEPTH; i++) r_dly_r[i] <= r_dly_r[i-1];
      z_dly_r[0] <= z_fp;
      for (int i = 1; i < Z_DEPTH; i++) z_dly_r[i] <= z_dly_r[i-1];
    end
  end

  // Numerator and denominator Horner chains, one multiply and one add per
  // step; the chains run side by side on the same r
  for (genvar k = 0; k < HS; k++) begin : g_horner
    ugi_pkg::fp32_t r_tap;
    ugi_pkg::fp32_t n_src;
    ugi_pkg::fp32_t d_src;
    logic           n_src_vld;
    logic           d_src_vld;

    if (k == 0) begin : g_lead
      assign r_tap     = r_fp;
      assign n_src     = ugi_pkg::COEF_A1;
      assign d_src     = ugi_pkg::COEF_B1;
      assign n_src_vld = r_vld;
      assign d_src_vld = r_vld;
    end else begin : g_step
      assign r_tap     = r_dly_r[4*k-1];
      assign n_src     = na_fp[k-1];
      assign d_src     = da_fp[k-1];
      assign n_src_vld = na_vld[k-1];
      assign d_src_vld = da_vld[k-1];
    end

    ugi_fmul u_nmul (
      .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(n_src_vld),
      .a(n_src), .b(r_tap), .out_vld(nm_vld[k]), .out_fp(nm_fp[k])
    );
    ugi_fadd u_nadd (
      .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(nm_vld[k]),
      .a(ugi_pkg::NUM_ADD[k]), .b(nm_fp[k]), .out_vld(na_vld[k]), .out_fp(na_fp[k])
    );
    ugi_fmul u_dmul (
      .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(d_src_vld),
      .a(d_src), .b(r_tap), .out_vld(dm_vld[k]), .out_fp(dm_fp[k])
    );
    ugi_fadd u_dadd (
      .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(dm_vld[k]),
      .a(ugi_pkg::DEN_ADD[k]), .b(dm_fp[k]), .out_vld(da_vld[k]), .out_fp(da_fp[k])
    );
  end

  // num = poly * z
  ugi_fmul u_numz (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(na_vld[HS-1]),
    .a(na_fp[HS-1]), .b(z_dly_r[Z_DEPTH-1]),
    .out_vld(nz_vld), .out_fp(nz_fp)
  );

  // t = 1 / den
  ugi_recip u_recip (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(da_vld[HS-1]),
    .den(da_fp[HS-1]),
    .out_vld(t_vld), .out_dz(t_dz), .out_fp(t_fp)
  );

  // Delay the numerator until the reciprocal is ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NZ_DEPTH; i++) nz_dly_vld_r[i] <= 1'b0;
    end else if (adv) begin
      nz_dly_vld_r[0] <= nz_vld;
      for (int i = 1; i < NZ_DEPTH; i++) nz_dly_vld_r[i] <= nz_dly_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nz_dly_r[0] <= nz_fp;
      for (int i = 1; i < NZ_DEPTH; i++) nz_dly_r[i] <= nz_dly_r[i-1];
    end
  end

  // sample = num * t
  ugi_fmul u_final (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(t_vld & nz_dly_vld_r[NZ_DEPTH-1]),
    .a(nz_dly_r[NZ_DEPTH-1]), .b(t_fp),
    .out_vld(p_vld), .out_fp(p_fp)
  );

  // Zero denominator: quiet NaN for a zero numerator, else signed infinity
  always_comb begin
    spec = t_dz;
    if (nz_dly_r[NZ_DEPTH-1][30:0] == 31'd0) begin
      spec_val = ugi_pkg::QNAN_BITS;
    end else begin
      spec_val = {nz_dly_r[NZ_DEPTH-1][31] ^ t_fp[31], ugi_pkg::INF_BITS[30:0]};
    end
  end

  // Carry the override alongside the final multiply
  always_ff @(posedge clk) begin
    if (adv) begin
      spec_d1_r     <= spec;
      spec_val_d1_r <= spec_val;
      spec_d2_r     <= spec_d1_r;
      spec_val_d2_r <= spec_val_d1_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_bits_r <= spec_d2_r ? spec_val_d2_r : p_fp;
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.gaussian_bits = out_bits_r;

endmodule

FILE: rtl/core/ugi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugi_checker: port-level checks for the Gaussian sampler
// Watches both channels and flags handshake and flow-control slips.
// ----------------------------------------------------------------------------
module ugi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_bits
);

  // Output stays offered while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  // Stalled sample holds its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bits))
    else $error("out payload changed while stalled");

  // Input is taken exactly when the output side can move
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in ready disagrees with output flow");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid after reset");

  // Leaving reset, no transaction reaches the output by bypassing the pipeline
  a_no_shortcut: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid [*2])
    else $error("transaction bypassed the pipeline");

endmodule

bind uniform_to_gaussian_icdf_core ugi_checker u_ugi_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_bits (out_ch.gaussian_bits)
);
